@@ hdl/doubly_linked_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_assert
// Assertion macros shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication under reset
`define DLLE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlle check failed");

// Next-cycle implication under reset
`define DLLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlle check failed");

`endif

@@ hdl/dlle_pkg.sv @@
// ----------------------------------------------------------------------------
// dlle_pkg
// Types and codes shared by the list engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none
package dlle_pkg;
	localparam logic [3:0] ACT_INS_FRONT  = 4'd0;
	localparam logic [3:0] ACT_INS_BACK   = 4'd1;
	localparam logic [3:0] ACT_INS_AFTER  = 4'd2;
	localparam logic [3:0] ACT_INS_BEFORE = 4'd3;
	localparam logic [3:0] ACT_GET_FRONT  = 4'd4;
	localparam logic [3:0] ACT_GET_BACK   = 4'd5;
	localparam logic [3:0] ACT_POP_FRONT  = 4'd6;
	localparam logic [3:0] ACT_POP_BACK   = 4'd7;
	localparam logic [3:0] ACT_RM_FRONT   = 4'd8;
	localparam logic [3:0] ACT_RM_BACK    = 4'd9;
	localparam logic [3:0] ACT_RM_KEY     = 4'd10;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [6:0]         length;
	} rsp_t;

	// per-cell update applied on execute
	typedef enum logic [2:0] {
		COP_HOLD,
		COP_PUSH_FRONT,
		COP_APPEND,
		COP_INS_AFTER,
		COP_INS_BEFORE,
		COP_POP_FRONT,
		COP_DROP_LAST,
		COP_RM_KEY
	} cop_t;

	typedef struct packed {
		cop_t               op;
		logic               clr;
		logic               step;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} cell_ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic signed [31:0] val;
		logic               valid;
		logic               prior;
		logic               incl;
	} nbr_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_EXEC
	} state_t;
endpackage
`default_nettype wire

@@ hdl/dlle_cell.sv @@
// ----------------------------------------------------------------------------
// dlle_cell
// One list position: value, occupancy and the key-prefix flag.
// ----------------------------------------------------------------------------
`default_nettype none
module dlle_cell
	import dlle_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cell_ctl_t   ctl,
	input  wire nbr_t        lft,
	input  wire nbr_t        rgt,
	output nbr_t             me,
	output logic signed [31:0] tap
);
	logic signed [31:0] val_q, val_d;
	logic valid_q, valid_d, prior_q, match;

	assign match = valid_q && (val_q == ctl.key);
	assign me.val = val_q;
	assign me.valid = valid_q;
	assign me.prior = prior_q;
	assign me.incl = prior_q | match;
	// last occupied cell exposes its value
	assign tap = (valid_q && !rgt.valid) ? val_q : 32'sd0;

	always_comb begin
		val_d = val_q;
		valid_d = valid_q;
		case (ctl.op)
			COP_PUSH_FRONT: begin
				val_d = lft.val;
				valid_d = lft.valid;
			end
			COP_APPEND: begin
				if (!valid_q && lft.valid) begin
					val_d = ctl.value;
					valid_d = 1'b1;
				end
			end
			COP_INS_AFTER: begin
				if (prior_q) begin
					val_d = lft.prior ? lft.val : ctl.value;
					valid_d = lft.prior ? lft.valid : 1'b1;
				end
			end
			COP_INS_BEFORE: begin
				if (me.incl) begin
					val_d = lft.incl ? lft.val : ctl.value;
					valid_d = lft.incl ? lft.valid : 1'b1;
				end
			end
			COP_POP_FRONT: begin
				val_d = rgt.val;
				valid_d = rgt.valid;
			end
			COP_DROP_LAST: begin
				if (valid_q && !rgt.valid) valid_d = 1'b0;
			end
			COP_RM_KEY: begin
				if (me.incl) begin
					val_d = rgt.val;
					valid_d = rgt.valid;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			prior_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			if (ctl.clr) prior_q <= 1'b0;
			else if (ctl.step) prior_q <= lft.incl;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end
endmodule
`default_nettype wire

@@ hdl/doubly_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_stall | action, key, value
// rsp     | out | rsp_valid/rsp_stall | result_value, status, length
//
// Front/back actions: accept in S_IDLE, then execute in S_EXEC.
// Key actions: accept, S_SEARCH, then execute; the match-prefix flag ripples
// one cell per cycle along the row in S_SEARCH before execute.
// Reset empties every cell at once; no clearing pass.
// rsp is a register: execute waits only while a finished result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module doubly_linked_list_engine
	import dlle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);

	state_t state_q, state_d;
	req_t req_q;
	logic [CW-1:0] count_q, count_d;
	logic [SW-1:0] scnt_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;
	logic accept, out_free, exec_go, found, is_key;
	cell_ctl_t ctl;
	cop_t op_d;
	nbr_t cell_l [CAPACITY];
	nbr_t cell_r [CAPACITY];
	nbr_t cell_o [CAPACITY];
	logic signed [31:0] taps [CAPACITY];
	logic signed [31:0] back_val;

	assign accept = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign exec_go = (state_q == S_EXEC) && out_free;
	assign is_key = (req.action == ACT_INS_AFTER) || (req.action == ACT_INS_BEFORE)
		|| (req.action == ACT_RM_KEY);
	assign found = cell_o[CAPACITY-1].incl;

	// neighbor wiring: the row's left end feeds the new value in
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0) begin
				cell_l[i].val = req_q.value;
				cell_l[i].valid = 1'b1;
				cell_l[i].prior = 1'b0;
				cell_l[i].incl = 1'b0;
			end else begin
				cell_l[i] = cell_o[i-1];
			end
			if (i == CAPACITY - 1) begin
				cell_r[i] = '0;
			end else begin
				cell_r[i] = cell_o[i+1];
			end
		end
	end

	always_comb begin
		back_val = '0;
		for (int i = 0; i < CAPACITY; i++) back_val = back_val | taps[i];
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		dlle_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.lft(cell_l[g]), .rgt(cell_r[g]), .me(cell_o[g]), .tap(taps[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = is_key ? S_SEARCH : S_EXEC;
			S_SEARCH: if (scnt_q == SW'(CAPACITY - 2)) state_d = S_EXEC;
			S_EXEC: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// decode the action against list state
	always_comb begin
		op_d = COP_HOLD;
		count_d = count_q;
		rsp_d.result_value = '0;
		rsp_d.status = ST_OK;
		case (req_q.action) inside
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AFTER, ACT_INS_BEFORE: begin
				if ((req_q.action == ACT_INS_AFTER || req_q.action == ACT_INS_BEFORE)
					&& !found) begin
					rsp_d.status = ST_NOT_FOUND;
				end else if (count_q == CW'(CAPACITY)) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
					case (req_q.action)
						ACT_INS_FRONT: op_d = COP_PUSH_FRONT;
						ACT_INS_BACK:  op_d = COP_APPEND;
						ACT_INS_AFTER: op_d = COP_INS_AFTER;
						default:       op_d = COP_INS_BEFORE;
					endcase
				end
			end
			[ACT_GET_FRONT:ACT_RM_BACK]: begin
				if (count_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					if (req_q.action <= ACT_POP_BACK)
						rsp_d.result_value = req_q.action[0] ? back_val : cell_o[0].val;
					if (req_q.action >= ACT_POP_FRONT) begin
						count_d = count_q - 1'b1;
						op_d = req_q.action[0] ? COP_DROP_LAST : COP_POP_FRONT;
					end
				end
			end
			ACT_RM_KEY: begin
				if (!found) begin
					rsp_d.status = ST_NOT_FOUND;
				end else begin
					count_d = count_q - 1'b1;
					op_d = COP_RM_KEY;
				end
			end
			default: begin
				op_d = COP_HOLD;
			end
		endcase
		rsp_d.length = 7'(count_d);
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = (state_q != S_IDLE);
		ctl.key = req_q.key;
		ctl.value = req_q.value;
		ctl.clr = accept;
		ctl.step = (state_q == S_SEARCH);
		ctl.op = exec_go ? op_d : COP_HOLD;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) scnt_q <= '0;
			else if (state_q == S_SEARCH) scnt_q <= scnt_q + 1'b1;
			if (exec_go) begin
				count_q <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (exec_go) rsp_q <= rsp_d;
	end

`include "doubly_linked_list_engine_assert.svh"
	`DLLE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(CAPACITY))
	`DLLE_ASSERT_NOW(a_front_cell, 1'b1, cell_o[0].valid == (count_q != '0))
	`DLLE_ASSERT_NEXT(a_rsp_hold, rsp_valid_q && rsp_stall, rsp_valid_q && $stable(rsp_q))
endmodule
`default_nettype wire

@@ bench/tb_doubly_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine
// Drives list actions through the request channel and checks every response
// against a behavioral list in the bench. Directed rows cover the empty and
// key-miss cases, a fill loop the full one; random traffic in idling phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_doubly_linked_list_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import dlle_pkg::*;

	localparam int CAP = 64;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1250;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	doubly_linked_list_engine #(.CAPACITY(CAP)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Behavioral list: ordered values, front at index 0.
	logic signed [31:0] contents[$];
	rsp_t pending_rsp[$];
	// Directed rows, some with a hand-typed response the predictor must match.
	typedef struct packed {
		req_t r;
		logic known;
		rsp_t want;
	} row_t;

	int errors = 0;
	int idle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Returns position of the first matching value, or -1.
	function automatic int find_first(logic signed [31:0] k);
		foreach (contents[i])
			if (contents[i] == k) return i;
		return -1;
	endfunction

	// Applies one request to the behavioral list and returns the response.
	function automatic rsp_t apply_action(req_t r);
		rsp_t o;
		int pos;
		o = '0;
		case (r.action)
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AFTER, ACT_INS_BEFORE: begin
				pos = 0;
				if (r.action == ACT_INS_AFTER || r.action == ACT_INS_BEFORE) begin
					pos = find_first(r.key);
					if (pos < 0) o.status = ST_NOT_FOUND;
				end
				if (o.status == ST_OK) begin
					if (contents.size() >= CAP) o.status = ST_FULL;
					else if (r.action == ACT_INS_FRONT) contents.push_front(r.value);
					else if (r.action == ACT_INS_BACK) contents.push_back(r.value);
					else if (r.action == ACT_INS_AFTER) contents.insert(pos + 1, r.value);
					else contents.insert(pos, r.value);
				end
			end
			ACT_GET_FRONT, ACT_GET_BACK, ACT_POP_FRONT, ACT_POP_BACK,
			ACT_RM_FRONT, ACT_RM_BACK: begin
				if (contents.size() == 0) o.status = ST_EMPTY;
				else begin
					// even codes work on the front
					pos = r.action[0] ? contents.size() - 1 : 0;
					if (r.action <= ACT_POP_BACK) o.result_value = contents[pos];
					if (r.action >= ACT_POP_FRONT) contents.delete(pos);
				end
			end
			ACT_RM_KEY: begin
				pos = find_first(r.key);
				if (pos < 0) o.status = ST_NOT_FOUND;
				else contents.delete(pos);
			end
			default: ;  // unused codes leave the list alone
		endcase
		o.length = 7'(contents.size());
		return o;
	endfunction

	// Response checking, sampled at the rising edge.
	int mismatches = 0;
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected response %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
				    rsp.length !== want.length) begin
					errors++;
					if (mismatches++ < 10)
						$display("response mismatch: expected %p got %p", want, rsp);
				end
			end
		end
	end

	// Receiver stall pattern.
	always @(posedge clk) begin
		if (!arst_n) rsp_stall <= 1'b0;
		else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sends one request; predicts on acceptance. Valid stays up for a
	// following request unless an idle gap is drawn.
	task automatic send_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(apply_action(r));
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -1;
			3: return 32'($urandom);
			default: return 32'($urandom_range(7));
		endcase
	endfunction

	function automatic req_t random_request();
		req_t r;
		int sel;
		r.value = pick_value();
		// keys usually hit a live node
		if (contents.size() > 0 && $urandom_range(3) != 0)
			r.key = contents[$urandom_range(contents.size() - 1)];
		else
			r.key = pick_value();
		sel = $urandom_range(99);
		// lean toward inserts while short, removals while long
		if (sel < 3) r.action = 4'($urandom_range(15, 11));
		else if (sel < (contents.size() < 32 ? 60 : 40))
			r.action = 4'($urandom_range(ACT_INS_BEFORE, ACT_INS_FRONT));
		else r.action = 4'($urandom_range(ACT_RM_KEY, ACT_GET_FRONT));
		return r;
	endfunction

	row_t directed[$];
	initial begin
		req_t r;
		rsp_t hint;
		row_t row;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list errors, key misses, extremes, ignored code
		directed.push_back('{'{ACT_GET_FRONT, 0, 0}, 1, '{0, ST_EMPTY, 0}});
		directed.push_back('{'{ACT_POP_BACK, 0, 0}, 1, '{0, ST_EMPTY, 0}});
		directed.push_back('{'{ACT_RM_FRONT, 0, 0}, 1, '{0, ST_EMPTY, 0}});
		directed.push_back('{'{ACT_RM_BACK, 0, 0}, 1, '{0, ST_EMPTY, 0}});
		directed.push_back('{'{ACT_RM_KEY, 5, 0}, 1, '{0, ST_NOT_FOUND, 0}});
		directed.push_back('{'{ACT_INS_AFTER, 5, 1}, 1, '{0, ST_NOT_FOUND, 0}});
		directed.push_back('{'{ACT_INS_FRONT, 0, 32'sh7fff_ffff}, 1, '{0, ST_OK, 1}});
		directed.push_back('{'{ACT_INS_BACK, 0, 32'sh8000_0000}, 1, '{0, ST_OK, 2}});
		directed.push_back('{'{ACT_GET_FRONT, 0, 0}, 1, '{32'sh7fff_ffff, ST_OK, 2}});
		directed.push_back('{'{ACT_GET_BACK, 0, 0}, 1, '{32'sh8000_0000, ST_OK, 2}});
		directed.push_back('{'{ACT_INS_AFTER, 32'sh7fff_ffff, 3}, 0, '0});
		directed.push_back('{'{ACT_INS_BEFORE, 32'sh8000_0000, 4}, 0, '0});
		directed.push_back('{'{ACT_INS_BEFORE, 32'sh7fff_ffff, 3}, 0, '0});
		directed.push_back('{'{4'd15, -1, -1}, 1, '{0, ST_OK, 5}});
		directed.push_back('{'{ACT_RM_KEY, 3, 0}, 0, '0});
		directed.push_back('{'{ACT_POP_FRONT, 0, 0}, 0, '0});
		directed.push_back('{'{ACT_POP_BACK, 0, 0}, 0, '0});
		directed.push_back('{'{ACT_RM_FRONT, 0, 0}, 0, '0});
		directed.push_back('{'{ACT_RM_BACK, 0, 0}, 1, '{0, ST_OK, 0}});
		foreach (directed[i]) begin
			row = directed[i];
			send_request(row.r);
			hint = pending_rsp[$];
			if (row.known && hint !== row.want) begin
				errors++;
				$display("table row %0d disagrees: table %p bench %p", i, row.want, hint);
			end
		end

		// fill the pool, overflow it, then drain it fully
		for (int i = 0; i < CAP + 2; i++) begin
			r.action = i[0] ? ACT_INS_BACK : ACT_INS_FRONT;
			r.key = 0;
			r.value = 32'(i);
			send_request(r);
		end
		r.action = ACT_INS_AFTER;
		r.key = 5;
		send_request(r);
		r.key = 32'sh1234_5678;
		send_request(r);
		for (int i = 0; i < CAP; i++) begin
			r.action = 4'($urandom_range(ACT_RM_BACK, ACT_POP_FRONT));
			send_request(r);
		end

		// random traffic in idling phases
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				3: begin send_idle_pct = 28; recv_stall_pct = 28; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int i = 0; i < N_RANDOM / 5; i++)
				send_request(random_request());
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (3 * CAP) @(posedge clk);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
